@@ hdl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and helpers of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CFG_IDX_W = 2;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_COLOR = 2'd1;
  localparam logic [ATTR_W-1:0]    TEXT_COLOR_RST  = 8'd15;
  localparam logic [ATTR_W-1:0]    BLANK_COLOR_RST = 8'd7;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } out_item_t;

  // One write port and one read port of the cell store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic cell_t make_cell(input logic [CHAR_W-1:0] ch,
                                      input logic [ATTR_W-1:0] attr);
    return {attr, ch};
  endfunction

  // Map a screen row to a store row; top is the store row shown first
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] r);
    logic [ROW_W:0] s;
    s = {1'b0, top} + {1'b0, r};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

@@ hdl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console with a character-cell screen store and a cursor.
// ----------------------------------------------------------------------------
// Each accepted item gives one result. Put of return, tab, backspace or a
// printable byte, a newline or wrap that does not scroll, and an unused func
// code finish in the cycle of the transfer when the output register is
// free; a read finishes in ST_RDWAIT, once the registered read data of the
// cell store is back. A newline, tab or wrap on the bottom row scrolls by
// rotating the row offset and blanking one row through the single write
// port, and a printable byte's cell is written after that row. Clear writes
// every cell. After reset a clearing pass over every cell runs with intake
// stalled; configuration writes are taken throughout. A finished result
// waits in the output register and does not hold up intake of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ATTR_W-1:0]    cfg_data
);

  logic [ATTR_W-1:0] text_color;
  logic [ATTR_W-1:0] blank_color;
  logic              out_free;
  logic              res_load;
  out_item_t         res;
  ram_req_t          ram_req;
  cell_t             ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color  <= TEXT_COLOR_RST;
      blank_color <= BLANK_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_COLOR:  text_color  <= cfg_data;
        REG_BLANK_COLOR: blank_color <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .text_color  (text_color),
    .blank_color (blank_color),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  tcw_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Output register: load a result, drop it after its transfer
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tcw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram
  import tcw_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output cell_t         rdata
);

  cell_t mem [CELL_COUNT];

  // Write and read the store
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Cursor, scroll offset and sequencer: decodes each item, writes cells,
// sweeps rows for scroll, clear and reset, and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire in_item_t    in_data,
  output logic             in_stall,
  input  wire logic [ATTR_W-1:0] text_color,
  input  wire logic [ATTR_W-1:0] blank_color,
  input  wire logic        out_free,
  output logic             res_load,
  output out_item_t        res,
  output ram_req_t         ram_req,
  input  wire cell_t       ram_rdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SWEEP  = 5'b00010,
    ST_WRITE  = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [ADDR_W-1:0] sweep_addr, sweep_addr_next;
  logic [ADDR_W-1:0] sweep_last, sweep_last_next;
  cell_t             fill, fill_next;
  logic              quiet, quiet_next;
  logic              pend_we, pend_we_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;
  cell_t             pend_data, pend_data_next;
  cell_t             res_cell, res_cell_next;
  logic              rd_ok, rd_ok_next;

  logic              accept;
  logic              adv;
  logic              scroll;
  logic              put_we;
  logic [ADDR_W-1:0] put_addr;
  cell_t             put_data;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic [ROW_W-1:0]  row_adv;
  logic [COL_W:0]    tab_col;
  logic              read_in_range;
  cell_t             cell_out;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Decode a put: new cursor and the cell it writes
  always_comb begin
    adv      = 1'b0;
    put_we   = 1'b0;
    put_data = make_cell(in_data.char_code, text_color);
    put_col  = col;
    put_addr = cell_addr(phys_row(top, row), col);
    row_adv  = (row == ROW_W'(ROWS - 1)) ? row : row + 1'b1;
    tab_col  = ({1'b0, col} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
    case (in_data.char_code)
      CH_NEWLINE: begin
        adv     = 1'b1;
        put_col = '0;
      end
      CH_RETURN: begin
        put_col = '0;
      end
      CH_TAB: begin
        if (tab_col >= (COL_W+1)'(COLUMNS)) begin
          adv     = 1'b1;
          put_col = '0;
        end else begin
          put_col = tab_col[COL_W-1:0];
        end
      end
      CH_BACKSPACE: begin
        if (col != '0) begin
          put_col  = col - 1'b1;
          put_we   = 1'b1;
          put_data = make_cell(CH_SPACE, blank_color);
          put_addr = cell_addr(phys_row(top, row), col - 1'b1);
        end
      end
      default: begin
        put_we = 1'b1;
        if (col >= COL_W'(COLUMNS)) begin
          adv      = 1'b1;
          put_col  = COL_W'(1);
          put_addr = cell_addr(phys_row(top, row_adv), '0);
        end else begin
          put_col = col + 1'b1;
        end
      end
    endcase
    put_row = adv ? row_adv : row;
    scroll  = adv && (row == ROW_W'(ROWS - 1));
  end

  assign read_in_range = (in_data.read_row < ROW_W'(ROWS)) &&
                         (in_data.read_col < COL_W'(COLUMNS));

  // Sequencer
  always_comb begin
    state_next      = state;
    col_next        = col;
    row_next        = row;
    top_next        = top;
    sweep_addr_next = sweep_addr;
    sweep_last_next = sweep_last;
    fill_next       = fill;
    quiet_next      = quiet;
    pend_we_next    = pend_we;
    pend_addr_next  = pend_addr;
    pend_data_next  = pend_data;
    res_cell_next   = res_cell;
    rd_ok_next      = rd_ok;
    res_load        = 1'b0;
    cell_out        = res_cell;
    ram_req.we      = 1'b0;
    ram_req.waddr   = sweep_addr;
    ram_req.wdata   = fill;
    ram_req.raddr   = read_in_range ?
                      cell_addr(phys_row(top, in_data.read_row), in_data.read_col) : '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_cell_next = '0;
          cell_out      = '0;
          case (in_data.func)
            FUNC_PUT: begin
              col_next = put_col;
              row_next = put_row;
              if (scroll) begin
                // Rotate the screen: the old top row becomes the blank bottom
                top_next        = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
                sweep_addr_next = cell_addr(top, '0);
                sweep_last_next = cell_addr(top, COL_W'(COLUMNS - 1));
                fill_next       = make_cell(CH_SPACE, blank_color);
                pend_we_next    = put_we;
                pend_addr_next  = cell_addr(top, '0);
                pend_data_next  = put_data;
                state_next      = ST_SWEEP;
              end else begin
                ram_req.we    = put_we;
                ram_req.waddr = put_addr;
                ram_req.wdata = put_data;
                res_load      = out_free;
                state_next    = out_free ? ST_IDLE : ST_FINISH;
              end
            end
            FUNC_CLEAR: begin
              col_next        = '0;
              row_next        = '0;
              top_next        = '0;
              sweep_addr_next = '0;
              sweep_last_next = ADDR_W'(CELL_COUNT - 1);
              fill_next       = make_cell(CH_SPACE, blank_color);
              pend_we_next    = 1'b0;
              state_next      = ST_SWEEP;
            end
            FUNC_READ: begin
              rd_ok_next = read_in_range;
              state_next = ST_RDWAIT;
            end
            default: begin
              res_load   = out_free;
              state_next = out_free ? ST_IDLE : ST_FINISH;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        ram_req.we      = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == sweep_last) begin
          if (quiet) begin
            quiet_next = 1'b0;
            state_next = ST_IDLE;
          end else if (pend_we) begin
            state_next = ST_WRITE;
          end else begin
            res_load   = out_free;
            state_next = out_free ? ST_IDLE : ST_FINISH;
          end
        end
      end
      ST_WRITE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pend_addr;
        ram_req.wdata = pend_data;
        pend_we_next  = 1'b0;
        res_load      = out_free;
        state_next    = out_free ? ST_IDLE : ST_FINISH;
      end
      ST_RDWAIT: begin
        cell_out      = rd_ok ? ram_rdata : '0;
        res_cell_next = cell_out;
        res_load      = out_free;
        state_next    = out_free ? ST_IDLE : ST_FINISH;
      end
      ST_FINISH: begin
        res_load   = out_free;
        state_next = out_free ? ST_IDLE : ST_FINISH;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res.cell_value = cell_out;
  assign res.cursor_col = col_next;
  assign res.cursor_row = row_next;

  // Control state; reset starts the clearing pass in the reset blank color
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      col        <= '0;
      row        <= '0;
      top        <= '0;
      sweep_addr <= '0;
      sweep_last <= ADDR_W'(CELL_COUNT - 1);
      fill       <= make_cell(CH_SPACE, BLANK_COLOR_RST);
      quiet      <= 1'b1;
      pend_we    <= 1'b0;
    end else begin
      state      <= state_next;
      col        <= col_next;
      row        <= row_next;
      top        <= top_next;
      sweep_addr <= sweep_addr_next;
      sweep_last <= sweep_last_next;
      fill       <= fill_next;
      quiet      <= quiet_next;
      pend_we    <= pend_we_next;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    pend_data <= pend_data_next;
    res_cell  <= res_cell_next;
    rd_ok     <= rd_ok_next;
  end

endmodule

`default_nettype wire

@@ hdl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker
  import tcw_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire out_item_t            out_data
);

  logic [1:0] inflight;

  // Count items taken in and not yet handed out
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 2'(in_valid && !in_stall) - 2'(out_valid && !out_stall);
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // Keep the cursor on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cursor_col <= COL_W'(COLUMNS)) &&
                  (out_data.cursor_row < ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  // Stall intake while the reset clearing pass runs
  a_reset_stall: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("intake open or result shown right after reset");

  // Show a result only for an item that is still owed one
  a_out_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inflight != 2'd0))
    else $error("result shown with no item outstanding");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
